[rtl/assert_macros.svh]
// Assertion macros shared by the glyph layout RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GLQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/glq_pkg.sv]
// Types, constants and helpers for the glyph quad layout block.
`default_nettype none

package glq_pkg;

  localparam int GLYPH_COUNT = 106;
  localparam int GLYPH_AW    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // scale register is UQ4.8 and used doubled, so products are shifted by 7
  localparam int SCALE_SHIFT = 7;
  localparam int SCALED_W    = 13;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  localparam logic [7:0] CHAR_SPACE       = 8'd32;
  localparam logic [7:0] CHAR_FIRST_GLYPH = 8'd33;

  localparam logic [8:0]  SPACE_UNITS = 9'd14;
  localparam logic [8:0]  RISE_UNITS  = 9'd10;
  localparam logic [15:0] LINE_GAP    = 16'd2;

  localparam logic [1:0] REG_SCALE     = 2'd0;
  localparam logic [1:0] REG_WRAP      = 2'd1;
  localparam logic [1:0] REG_MAX_WIDTH = 2'd2;
  localparam logic [1:0] REG_COLOR     = 2'd3;

  localparam logic [11:0] SCALE_RESET     = 12'd256;
  localparam logic [15:0] MAX_WIDTH_RESET = 16'hFFFF;
  localparam logic [31:0] COLOR_RESET     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        char_code;
    logic [6:0]        glyph_index;
    logic [7:0]        glyph_tex_x;
    logic [7:0]        glyph_tex_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] glyph_drop;
    logic [15:0]       start_x;
    logic [15:0]       start_y;
  } glq_item_t;

  typedef struct packed {
    logic signed [15:0] screen_x0;
    logic signed [15:0] screen_y0;
    logic signed [15:0] screen_x1;
    logic signed [15:0] screen_y1;
    logic [8:0]         tex_u0;
    logic [8:0]         tex_v0;
    logic [8:0]         tex_u1;
    logic [8:0]         tex_v1;
    logic [31:0]        quad_color;
  } glq_quad_t;

  typedef struct packed {
    logic [7:0]        tex_x;
    logic [7:0]        tex_y;
    logic [7:0]        width;
    logic [7:0]        height;
    logic signed [7:0] drop;
  } glq_glyph_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SPACE = 2'd1,
    OP_GLYPH = 2'd2
  } glq_op_t;

  typedef struct packed {
    glq_op_t     op;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } glq_lookup_t;

  typedef struct packed {
    glq_op_t              op;
    logic [15:0]          start_x;
    logic [15:0]          start_y;
    logic [SCALED_W-1:0]  adv;
    logic [SCALED_W-1:0]  width_s;
    logic [SCALED_W-1:0]  height_s;
    logic signed [SCALED_W:0] drop_s;
    logic [8:0]           tex_u0;
    logic [8:0]           tex_v0;
    logic [8:0]           tex_u1;
    logic [8:0]           tex_v1;
  } glq_scaled_t;

  typedef struct packed {
    logic [15:0]          x0;
    logic [15:0]          y;
    logic [SCALED_W-1:0]  width_s;
    logic [SCALED_W-1:0]  height_s;
    logic signed [SCALED_W:0] drop_s;
    logic [8:0]           tex_u0;
    logic [8:0]           tex_v0;
    logic [8:0]           tex_u1;
    logic [8:0]           tex_v1;
  } glq_placed_t;

  // trunc(v * scale / 128); v is at most 256, so the result fits 13 bits
  function automatic logic [SCALED_W-1:0] scale_u9(input logic [8:0] v,
                                                   input logic [11:0] s);
    logic [20:0] prod;
    prod = {12'd0, v} * {9'd0, s};
    return prod[SCALE_SHIFT +: SCALED_W];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/glq_table.sv]
// Glyph table memory and request decode stage.
`default_nettype none

module glq_table import glq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire glq_item_t   item,
  input  wire logic        item_valid,
  output logic             item_ready,
  output glq_lookup_t      look,
  output glq_glyph_t       glyph,
  output logic             look_valid,
  input  wire logic        look_ready
);

  glq_glyph_t           mem [GLYPH_COUNT];
  glq_glyph_t           wr_data;
  glq_op_t              op_next;
  logic [GLYPH_AW-1:0]  wr_addr;
  logic [GLYPH_AW-1:0]  rd_addr;
  logic [8:0]           code_off;
  logic                 take;
  logic                 is_char;
  logic                 is_space;
  logic                 is_glyph;
  logic                 is_start;
  logic                 wr_en;
  logic                 rd_en;
  logic                 keep;

  assign item_ready = !look_valid || look_ready;
  assign take       = item_valid && item_ready;

  assign code_off = {1'b0, item.char_code} - {1'b0, CHAR_FIRST_GLYPH};
  assign is_char  = (item.action == ACT_CHAR);
  assign is_start = (item.action == ACT_START);
  assign is_space = is_char && (item.char_code == CHAR_SPACE);
  assign is_glyph = is_char && (item.char_code >= CHAR_FIRST_GLYPH)
                    && (code_off < 9'(GLYPH_COUNT));

  assign wr_en   = take && (item.action == ACT_WRITE)
                   && ({2'b00, item.glyph_index} < 9'(GLYPH_COUNT));
  assign wr_addr = GLYPH_AW'(item.glyph_index);
  assign rd_en   = take && is_glyph;
  assign rd_addr = code_off[GLYPH_AW-1:0];
  assign keep    = is_start || is_space || is_glyph;

  assign wr_data.tex_x  = item.glyph_tex_x;
  assign wr_data.tex_y  = item.glyph_tex_y;
  assign wr_data.width  = item.glyph_width;
  assign wr_data.height = item.glyph_height;
  assign wr_data.drop   = item.glyph_drop;

  always_comb begin
    if (is_start) begin
      op_next = OP_START;
    end else if (is_space) begin
      op_next = OP_SPACE;
    end else begin
      op_next = OP_GLYPH;
    end
  end

  // read data only moves when a new glyph request enters, so it holds under stall
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      glyph <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid <= 1'b0;
    end else if (item_ready) begin
      look_valid <= take && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      look.op      <= op_next;
      look.start_x <= item.start_x;
      look.start_y <= item.start_y;
    end
  end

endmodule

`default_nettype wire

[rtl/glq_scale.sv]
// Scaling stage: glyph metrics times the text scale, texture corners.
`default_nettype none

module glq_scale import glq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [11:0]  scale_fx,
  input  wire glq_lookup_t  look,
  input  wire glq_glyph_t   glyph,
  input  wire logic         look_valid,
  output logic              look_ready,
  output glq_scaled_t       scaled,
  output logic              scaled_valid,
  input  wire logic         scaled_ready
);

  glq_scaled_t          scaled_next;
  logic [8:0]           drop_mag;
  logic [SCALED_W-1:0]  drop_abs;
  logic                 take;

  assign look_ready = !scaled_valid || scaled_ready;
  assign take       = look_valid && look_ready;

  // scaling of a negative offset truncates toward zero: scale the magnitude
  assign drop_mag = glyph.drop[7] ? (9'd0 - {glyph.drop[7], glyph.drop})
                                  : {1'b0, glyph.drop};
  assign drop_abs = scale_u9(drop_mag, scale_fx);

  always_comb begin
    scaled_next.op       = look.op;
    scaled_next.start_x  = look.start_x;
    scaled_next.start_y  = look.start_y;
    scaled_next.adv      = scale_u9({1'b0, glyph.width} + 9'd1, scale_fx);
    scaled_next.width_s  = scale_u9({1'b0, glyph.width}, scale_fx);
    scaled_next.height_s = scale_u9({1'b0, glyph.height}, scale_fx);
    scaled_next.drop_s   = glyph.drop[7] ? -$signed({1'b0, drop_abs})
                                         : $signed({1'b0, drop_abs});
    scaled_next.tex_u0   = {1'b0, glyph.tex_x};
    scaled_next.tex_v0   = {1'b0, glyph.tex_y};
    scaled_next.tex_u1   = {1'b0, glyph.tex_x} + {1'b0, glyph.width};
    scaled_next.tex_v1   = {1'b0, glyph.tex_y} + {1'b0, glyph.height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid <= 1'b0;
    end else if (look_ready) begin
      scaled_valid <= look_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scaled <= scaled_next;
    end
  end

endmodule

`default_nettype wire

[rtl/glq_pen.sv]
// Pen state and line wrapping; places each glyph quad.
`default_nettype none
`include "assert_macros.svh"

module glq_pen import glq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [11:0]  scale_fx,
  input  wire logic         wrap_enable,
  input  wire logic [15:0]  max_width,
  input  wire glq_scaled_t  scaled,
  input  wire logic         scaled_valid,
  output logic              scaled_ready,
  output glq_placed_t       placed,
  output logic              placed_valid,
  input  wire logic         placed_ready
);

  logic [15:0]          pen_x;
  logic [15:0]          pen_y;
  logic [15:0]          line_start_x;
  logic [15:0]          line_tallest;
  logic [15:0]          pen_x_next;
  logic [15:0]          pen_y_next;
  logic [15:0]          line_start_x_next;
  logic [15:0]          line_tallest_next;
  logic [15:0]          tallest_max;
  logic [15:0]          trial;
  logic [15:0]          origin_x;
  logic [15:0]          origin_y;
  logic [SCALED_W-1:0]  space_step;
  logic                 wrap_now;
  logic                 fire;

  assign scaled_ready = !placed_valid || placed_ready;
  assign fire         = scaled_valid && scaled_ready;

  assign space_step  = scale_u9(SPACE_UNITS, scale_fx);
  assign tallest_max = (line_tallest < 16'(scaled.height_s)) ? 16'(scaled.height_s)
                                                             : line_tallest;
  assign trial       = pen_x + 16'(scaled.adv);
  assign wrap_now    = wrap_enable && ((trial - line_start_x) > max_width);
  // the new line drops by the tallest glyph including this one, which is then lost
  assign origin_x    = wrap_now ? line_start_x : pen_x;
  assign origin_y    = wrap_now ? (pen_y + tallest_max + LINE_GAP) : pen_y;

  always_comb begin
    pen_x_next        = pen_x;
    pen_y_next        = pen_y;
    line_start_x_next = line_start_x;
    line_tallest_next = line_tallest;
    case (scaled.op)
      OP_START: begin
        pen_x_next        = scaled.start_x;
        pen_y_next        = scaled.start_y;
        line_start_x_next = scaled.start_x;
        line_tallest_next = '0;
      end
      OP_SPACE: begin
        pen_x_next = pen_x + 16'(space_step);
      end
      OP_GLYPH: begin
        pen_x_next = origin_x + 16'(scaled.adv);
        pen_y_next = origin_y;
        if (wrap_enable) begin
          line_tallest_next = wrap_now ? 16'd0 : tallest_max;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      line_start_x <= '0;
      line_tallest <= '0;
      placed_valid <= 1'b0;
    end else begin
      if (fire) begin
        pen_x        <= pen_x_next;
        pen_y        <= pen_y_next;
        line_start_x <= line_start_x_next;
        line_tallest <= line_tallest_next;
      end
      if (scaled_ready) begin
        placed_valid <= fire && (scaled.op == OP_GLYPH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      placed.x0       <= origin_x;
      placed.y        <= origin_y;
      placed.width_s  <= scaled.width_s;
      placed.height_s <= scaled.height_s;
      placed.drop_s   <= scaled.drop_s;
      placed.tex_u0   <= scaled.tex_u0;
      placed.tex_v0   <= scaled.tex_v0;
      placed.tex_u1   <= scaled.tex_u1;
      placed.tex_v1   <= scaled.tex_v1;
    end
  end

  `GLQ_ASSERT_NEXT(pen_holds_when_idle, clk, rst, !fire, $stable(pen_x) && $stable(pen_y) && $stable(line_start_x))
  `GLQ_ASSERT_NEXT(start_opens_line, clk, rst, fire && scaled.op == OP_START, line_tallest == 16'd0 && pen_x == line_start_x)

endmodule

`default_nettype wire

[rtl/glq_core_out.sv]
// Output stage: final quad corners with saturation, result register.
`default_nettype none
`include "assert_macros.svh"

module glq_core_out import glq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [11:0]  scale_fx,
  input  wire logic [31:0]  text_color,
  input  wire glq_placed_t  placed,
  input  wire logic         placed_valid,
  output logic              placed_ready,
  output glq_quad_t         quad,
  output logic              quad_valid,
  input  wire logic         quad_ready
);

  glq_quad_t            quad_next;
  logic [SCALED_W-1:0]  rise;
  logic signed [18:0]   x0_w;
  logic signed [18:0]   x1_w;
  logic signed [18:0]   y0_w;
  logic signed [18:0]   y1_w;

  assign placed_ready = !quad_valid || quad_ready;
  assign rise         = scale_u9(RISE_UNITS, scale_fx);

  assign x0_w = $signed({3'b000, placed.x0});
  assign x1_w = x0_w + $signed({6'd0, placed.width_s});
  assign y0_w = $signed({3'b000, placed.y})
                + $signed({{5{placed.drop_s[SCALED_W]}}, placed.drop_s})
                + $signed({6'd0, rise});
  assign y1_w = y0_w + $signed({6'd0, placed.height_s});

  always_comb begin
    quad_next.screen_x0  = sat16(x0_w);
    quad_next.screen_y0  = sat16(y0_w);
    quad_next.screen_x1  = sat16(x1_w);
    quad_next.screen_y1  = sat16(y1_w);
    quad_next.tex_u0     = placed.tex_u0;
    quad_next.tex_v0     = placed.tex_v0;
    quad_next.tex_u1     = placed.tex_u1;
    quad_next.tex_v1     = placed.tex_v1;
    quad_next.quad_color = text_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
    end else if (placed_ready) begin
      quad_valid <= placed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (placed_valid && placed_ready) begin
      quad <= quad_next;
    end
  end

  `GLQ_ASSERT_IMP(quad_x_ordered, clk, rst, quad_valid, quad.screen_x1 >= quad.screen_x0)
  `GLQ_ASSERT_IMP(quad_y_ordered, clk, rst, quad_valid, quad.screen_y1 >= quad.screen_y0)

endmodule

`default_nettype wire

[rtl/glyph_quad_layout_core.sv]
// Glyph quad layout engine: top level with configuration registers.
//
// Requests enter on item / item_valid / item_ready: glyph table writes, string
// starts and characters. Each printable glyph yields one quad on quad /
// quad_valid / quad_ready; spaces, starts, table writes and unprintable
// characters yield none.
// A taken request passes the table, scale, pen and output registers in turn, the
// last driving quad_valid. Without a receiver stall one request is taken per cycle:
// the table memory read, scaling multipliers, pen update and saturating corner
// adders are each one registered stage, and the pen update reads the pen registers.
// When the receiver stalls, requests back up stage by stage; item_ready drops
// only once an untaken quad sits in the output register and every stage before
// it is occupied.
// Registers (APB, byte address 4*i): scale_fx, wrap_enable, max_width,
// text_color. Write them only while no request is in flight.
// Reset puts the pen, line start and tallest height at zero and the registers
// at their defaults. Glyph table contents are undefined until written; there
// is no clearing pass, so the block takes requests straight after reset.
`default_nettype none

module glyph_quad_layout_core import glq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire glq_item_t   item,
  input  wire logic        item_valid,
  output logic             item_ready,
  output glq_quad_t        quad,
  output logic             quad_valid,
  input  wire logic        quad_ready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [11:0]  scale_fx;
  logic         wrap_enable;
  logic [15:0]  max_width;
  logic [31:0]  text_color;
  logic         reg_write;

  glq_lookup_t  look;
  glq_glyph_t   glyph;
  logic         look_valid;
  logic         look_ready;
  glq_scaled_t  scaled;
  logic         scaled_valid;
  logic         scaled_ready;
  glq_placed_t  placed;
  logic         placed_valid;
  logic         placed_ready;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_fx    <= SCALE_RESET;
      wrap_enable <= 1'b0;
      max_width   <= MAX_WIDTH_RESET;
      text_color  <= COLOR_RESET;
    end else if (reg_write) begin
      unique case (paddr[3:2])
        REG_SCALE:     scale_fx    <= pwdata[11:0];
        REG_WRAP:      wrap_enable <= pwdata[0];
        REG_MAX_WIDTH: max_width   <= pwdata[15:0];
        REG_COLOR:     text_color  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE:     prdata = {20'd0, scale_fx};
      REG_WRAP:      prdata = {31'd0, wrap_enable};
      REG_MAX_WIDTH: prdata = {16'd0, max_width};
      REG_COLOR:     prdata = text_color;
      default:       prdata = '0;
    endcase
  end

  glq_table u_table (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .look       (look),
    .glyph      (glyph),
    .look_valid (look_valid),
    .look_ready (look_ready)
  );

  glq_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .scale_fx     (scale_fx),
    .look         (look),
    .glyph        (glyph),
    .look_valid   (look_valid),
    .look_ready   (look_ready),
    .scaled       (scaled),
    .scaled_valid (scaled_valid),
    .scaled_ready (scaled_ready)
  );

  glq_pen u_pen (
    .clk          (clk),
    .rst          (rst),
    .scale_fx     (scale_fx),
    .wrap_enable  (wrap_enable),
    .max_width    (max_width),
    .scaled       (scaled),
    .scaled_valid (scaled_valid),
    .scaled_ready (scaled_ready),
    .placed       (placed),
    .placed_valid (placed_valid),
    .placed_ready (placed_ready)
  );

  glq_core_out u_out (
    .clk          (clk),
    .rst          (rst),
    .scale_fx     (scale_fx),
    .text_color   (text_color),
    .placed       (placed),
    .placed_valid (placed_valid),
    .placed_ready (placed_ready),
    .quad         (quad),
    .quad_valid   (quad_valid),
    .quad_ready   (quad_ready)
  );

endmodule

`default_nettype wire

[tb/sv/glq_layout_checker.sv]
`timescale 1ns / 100ps
// Watches the glyph layout core's ports, predicts each quad and compares it.
module glq_layout_checker import glq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  glq_item_t   item,
  input  logic        item_valid,
  input  logic        item_ready,
  input  glq_quad_t   quad,
  input  logic        quad_valid,
  input  logic        quad_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  glq_glyph_t  glyph_mem [GLYPH_COUNT];
  logic [15:0] pen_x, pen_y, line_start_x, line_tallest;
  logic [11:0] scale_r;
  logic        wrap_r;
  logic [15:0] max_width_r;
  logic [31:0] color_r;
  glq_quad_t   quads_due [$];
  int          quads_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    quads_seen = 0;
  end

  function automatic int unsigned scaled(input int unsigned v);
    return (v * scale_r) >> SCALE_SHIFT;
  endfunction

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) begin
      return 16'h7FFF;
    end
    if (v < -32768) begin
      return 16'h8000;
    end
    return 16'(v);
  endfunction

  // Advances the layout state by one request; returns 1 when a quad is due.
  function automatic bit lay_out(input glq_item_t r, output glq_quad_t q);
    glq_glyph_t  g;
    int unsigned adv, hs;
    int          drop_v, x0, y0;
    logic [15:0] trial;
    q = '0;
    if (r.action == ACT_WRITE) begin
      if (r.glyph_index < GLYPH_COUNT) begin
        glyph_mem[r.glyph_index] = '{tex_x: r.glyph_tex_x, tex_y: r.glyph_tex_y,
                                     width: r.glyph_width, height: r.glyph_height,
                                     drop: r.glyph_drop};
      end
      return 0;
    end
    if (r.action == ACT_START) begin
      pen_x        = r.start_x;
      line_start_x = r.start_x;
      pen_y        = r.start_y;
      line_tallest = '0;
      return 0;
    end
    if (r.action != ACT_CHAR) begin
      return 0;
    end
    if (r.char_code == CHAR_SPACE) begin
      pen_x = 16'(pen_x + scaled(SPACE_UNITS));
      return 0;
    end
    if (r.char_code < CHAR_FIRST_GLYPH || r.char_code - CHAR_FIRST_GLYPH >= GLYPH_COUNT) begin
      return 0;
    end
    g   = glyph_mem[r.char_code - CHAR_FIRST_GLYPH];
    adv = scaled(int'(g.width) + 1);
    hs  = scaled(g.height);
    if (wrap_r) begin
      if (line_tallest < hs) begin
        line_tallest = 16'(hs);
      end
      trial = 16'(pen_x + adv);
      // new line drops the tallest height, current glyph included
      if (16'(trial - line_start_x) > max_width_r) begin
        pen_y        = 16'(pen_y + line_tallest + LINE_GAP);
        line_tallest = '0;
        pen_x        = line_start_x;
      end
    end
    drop_v = g.drop;
    if (drop_v < 0) begin
      drop_v = -int'(scaled(-drop_v));
    end else begin
      drop_v = int'(scaled(drop_v));
    end
    x0 = int'(pen_x);
    y0 = int'(pen_y) + drop_v + int'(scaled(RISE_UNITS));
    q.screen_x0  = clamp16(x0);
    q.screen_y0  = clamp16(y0);
    q.screen_x1  = clamp16(x0 + int'(scaled(g.width)));
    q.screen_y1  = clamp16(y0 + int'(hs));
    q.tex_u0     = {1'b0, g.tex_x};
    q.tex_v0     = {1'b0, g.tex_y};
    q.tex_u1     = {1'b0, g.tex_x} + {1'b0, g.width};
    q.tex_v1     = {1'b0, g.tex_y} + {1'b0, g.height};
    q.quad_color = color_r;
    pen_x = 16'(pen_x + adv);
    return 1;
  endfunction

  task automatic log_error(input string msg);
    if (fail_count < 40) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_error($sformatf("quad %0d %s: got %h, want %h", quads_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    glq_quad_t   q;
    glq_quad_t   want;
    logic [31:0] reg_value;
    if (rst) begin
      foreach (glyph_mem[i]) begin
        glyph_mem[i] = '0;
      end
      pen_x        = '0;
      pen_y        = '0;
      line_start_x = '0;
      line_tallest = '0;
      scale_r      = SCALE_RESET;
      wrap_r       = 1'b0;
      max_width_r  = MAX_WIDTH_RESET;
      color_r      = COLOR_RESET;
      quads_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_SCALE:     scale_r     = pwdata[11:0];
            REG_WRAP:      wrap_r      = pwdata[0];
            REG_MAX_WIDTH: max_width_r = pwdata[15:0];
            REG_COLOR:     color_r     = pwdata;
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_SCALE:     reg_value = {20'd0, scale_r};
            REG_WRAP:      reg_value = {31'd0, wrap_r};
            REG_MAX_WIDTH: reg_value = {16'd0, max_width_r};
            default:       reg_value = color_r;
          endcase
          if (prdata !== reg_value) begin
            log_error($sformatf("register read at %h: got %h, want %h",
                                paddr, prdata, reg_value));
          end
        end
      end
      if (item_valid && item_ready) begin
        if (lay_out(item, q)) begin
          quads_due.push_back(q);
        end
      end
      if (quad_valid && quad_ready) begin
        if (quads_due.size() == 0) begin
          log_error($sformatf("quad %0d arrived with none expected", quads_seen));
        end else begin
          want = quads_due.pop_front();
          check_field("screen_x0", quad.screen_x0, want.screen_x0);
          check_field("screen_y0", quad.screen_y0, want.screen_y0);
          check_field("screen_x1", quad.screen_x1, want.screen_x1);
          check_field("screen_y1", quad.screen_y1, want.screen_y1);
          check_field("tex_u0", quad.tex_u0, want.tex_u0);
          check_field("tex_v0", quad.tex_v0, want.tex_v0);
          check_field("tex_u1", quad.tex_u1, want.tex_u1);
          check_field("tex_v1", quad.tex_v1, want.tex_v1);
          check_field("quad_color", quad.quad_color, want.quad_color);
        end
        quads_seen++;
      end
    end
    pending = quads_due.size();
  end

endmodule

[tb/sv/tb_glyph_quad_layout_core.sv]
`timescale 1ns / 100ps
// Testbench top for the glyph quad layout core: stimulus, register set-up and verdict.
module tb_glyph_quad_layout_core;
  import glq_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;   // unused action code
  localparam int STALL_LIMIT    = 1000;
  localparam int WORK_PER_PHASE = 100;
  localparam int PHASES         = 8;
  localparam int SETTLE_CYCLES  = 8;

  logic        clk;
  logic        rst;
  glq_item_t   item;
  logic        item_valid;
  logic        item_ready;
  glq_quad_t   quad;
  logic        quad_valid;
  logic        quad_ready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  bit tx_idle;
  bit rx_idle;
  bit written [GLYPH_COUNT];
  int work_done;
  int idle_cycles = 0;

  glyph_quad_layout_core dut (.*);

  glq_layout_checker quad_check (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ends the run if nothing is accepted on any port for too long
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (quad_valid && quad_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic glq_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(glq_item_t)-1:0];
  endfunction

  function automatic glq_item_t glyph_entry(input int idx, input logic [7:0] tx,
                                            input logic [7:0] ty, input logic [7:0] w,
                                            input logic [7:0] h, input logic [7:0] drop);
    glq_item_t r;
    r = noise_item();
    r.action       = ACT_WRITE;
    r.glyph_index  = 7'(idx);
    r.glyph_tex_x  = tx;
    r.glyph_tex_y  = ty;
    r.glyph_width  = w;
    r.glyph_height = h;
    r.glyph_drop   = drop;
    return r;
  endfunction

  function automatic glq_item_t random_entry(input int idx);
    glq_item_t r;
    r = noise_item();
    r.action      = ACT_WRITE;
    r.glyph_index = 7'(idx);
    // narrow glyphs keep lines long enough to reach the wrap point
    if ($urandom_range(0, 1) == 1) begin
      r.glyph_width  = 8'($urandom_range(0, 24));
      r.glyph_height = 8'($urandom_range(0, 40));
    end
    return r;
  endfunction

  function automatic glq_item_t start_req(input logic [15:0] x, input logic [15:0] y);
    glq_item_t r;
    r = noise_item();
    r.action  = ACT_START;
    r.start_x = x;
    r.start_y = y;
    return r;
  endfunction

  function automatic glq_item_t char_req(input logic [7:0] code);
    glq_item_t r;
    r = noise_item();
    r.action    = ACT_CHAR;
    r.char_code = code;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(input glq_item_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = r;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    item_valid = 1'b0;
    case (r.action)
      ACT_WRITE: begin
        if (r.glyph_index < GLYPH_COUNT) begin
          written[r.glyph_index] = 1'b1;
          work_done++;
        end
      end
      ACT_START: work_done++;
      ACT_CHAR: begin
        if (r.char_code == CHAR_SPACE ||
            (r.char_code >= CHAR_FIRST_GLYPH &&
             r.char_code - CHAR_FIRST_GLYPH < GLYPH_COUNT)) begin
          work_done++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic read_back();
    apb_access(1'b0, REG_SCALE, '0);
    apb_access(1'b0, REG_WRAP, '0);
    apb_access(1'b0, REG_MAX_WIDTH, '0);
    apb_access(1'b0, REG_COLOR, '0);
  endtask

  task automatic set_layout(input logic [11:0] scale, input logic wrap,
                            input logic [15:0] max_w, input logic [31:0] color);
    apb_access(1'b1, REG_SCALE, {20'd0, scale});
    apb_access(1'b1, REG_WRAP, {31'd0, wrap});
    apb_access(1'b1, REG_MAX_WIDTH, {16'd0, max_w});
    apb_access(1'b1, REG_COLOR, color);
    read_back();
  endtask

  // A start request followed by a run of characters with some noise mixed in.
  task automatic send_string();
    int          n;
    int          roll;
    int          code;
    logic [15:0] sx;
    logic [15:0] sy;
    glq_item_t   r;
    sx = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1000));
    sy = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    push_request(start_req(sx, sy));
    n = $urandom_range(2, 20);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        code = $urandom_range(CHAR_FIRST_GLYPH, CHAR_FIRST_GLYPH + GLYPH_COUNT - 1);
        if (!written[code - CHAR_FIRST_GLYPH]) begin
          push_request(random_entry(code - CHAR_FIRST_GLYPH));
        end
        push_request(char_req(8'(code)));
      end else if (roll < 82) begin
        push_request(char_req(CHAR_SPACE));
      end else if (roll < 90) begin
        code = ($urandom_range(0, 1) == 1) ? $urandom_range(0, CHAR_SPACE - 1)
                                            : $urandom_range(CHAR_FIRST_GLYPH + GLYPH_COUNT, 255);
        push_request(char_req(8'(code)));
      end else if (roll < 95) begin
        push_request(random_entry($urandom_range(0, 127)));
      end else if (roll < 98) begin
        r = noise_item();
        r.action = ACT_NONE;
        push_request(r);
      end else begin
        push_request(start_req(16'($urandom), 16'($urandom)));
      end
    end
  endtask

  // quad_ready: a random stall before each result, none in phases that clear rx_idle
  initial begin : receiver
    int stall;
    quad_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        quad_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      quad_ready = 1'b1;
      do @(posedge clk); while (!(quad_valid && quad_ready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    glq_item_t r;
    rst        = 1'b1;
    item       = '0;
    item_valid = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    work_done  = 0;
    foreach (written[i]) begin
      written[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // register defaults, then the directed requests at reset settings
    read_back();
    push_request(glyph_entry(0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h80));
    push_request(glyph_entry(GLYPH_COUNT - 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F));
    push_request(glyph_entry(1, 8'd8, 8'd16, 8'd5, 8'd9, 8'd3));
    push_request(glyph_entry(127, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5));
    push_request(glyph_entry(GLYPH_COUNT, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5));
    r = noise_item();
    r.action = ACT_NONE;
    push_request(r);
    push_request(start_req(16'd0, 16'd0));
    push_request(char_req(CHAR_FIRST_GLYPH));
    push_request(char_req(8'(CHAR_FIRST_GLYPH + GLYPH_COUNT - 1)));
    push_request(char_req(8'(CHAR_FIRST_GLYPH + 1)));
    push_request(char_req(CHAR_SPACE));
    push_request(char_req(8'd0));
    push_request(char_req(8'(CHAR_SPACE - 1)));
    push_request(char_req(8'(CHAR_FIRST_GLYPH + GLYPH_COUNT)));
    push_request(char_req(8'hFF));
    // pen at the top of the range: corners saturate
    push_request(start_req(16'hFFFF, 16'hFFFF));
    push_request(char_req(8'(CHAR_FIRST_GLYPH + GLYPH_COUNT - 1)));
    push_request(char_req(CHAR_FIRST_GLYPH));
    push_request(char_req(CHAR_SPACE));
    push_request(char_req(8'(CHAR_FIRST_GLYPH + 1)));
    push_request(start_req(16'h7FF0, 16'h7FF0));
    push_request(char_req(8'(CHAR_FIRST_GLYPH + GLYPH_COUNT - 1)));

    for (int p = 1; p <= PHASES; p++) begin
      // registers change only with the pipe empty
      while (pending != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      tx_idle = (p % 3 != 2);
      rx_idle = (p % 4 != 3);
      case (p)
        1: set_layout(12'd256, 1'b1, 16'd300, $urandom);
        2: set_layout(12'd4095, 1'b0, 16'hFFFF, 32'h0);
        3: set_layout(12'd0, 1'b1, 16'd0, 32'hFFFF_FFFF);
        4: set_layout(12'd4095, 1'b1, 16'hFFFF, $urandom);
        5: set_layout(12'd1, 1'b1, 16'd0, $urandom);
        6: set_layout(12'($urandom_range(2048, 4095)), 1'b1,
                      16'($urandom_range(100, 4000)), $urandom);
        default: set_layout(12'($urandom), 1'($urandom),
                            16'($urandom_range(0, 3000)), $urandom);
      endcase
      work_done = 0;
      while (work_done < WORK_PER_PHASE) begin
        send_string();
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES + 2) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
